[hw/rtl/deadline_ordered_task_table_unit_assert.svh]
// assertion macros used by the checker file
`ifndef DEADLINE_ORDERED_TASK_TABLE_UNIT_ASSERT_SVH
`define DEADLINE_ORDERED_TASK_TABLE_UNIT_ASSERT_SVH

// property must hold at every clock edge outside reset
`define DOTT_ASSERT_IMPL(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dott assertion failed");

// condition must never be seen outside reset
`define DOTT_ASSERT_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("dott forbidden condition seen");

`endif

[hw/rtl/dott_pkg.sv]
// package: widths, status codes, controller states and command/status structs
`default_nettype none

package dott_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int KIND_W   = 8;
    localparam int NUM_W    = 10;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int KEY_W    = KIND_W + NUM_W;
    localparam int DATE_W   = MONTH_W + DAY_W;
    localparam int ENTRY_W  = KEY_W + DATE_W;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 4;
    localparam int OCC_W    = 5;

    typedef enum logic [STATUS_W-1:0] {
        ST_UPDATED   = 3'd0,
        ST_ADDED     = 3'd1,
        ST_UNCHANGED = 3'd2,
        ST_FULL      = 3'd3,
        ST_ON_TIME   = 3'd4,
        ST_OVERDUE   = 3'd5,
        ST_NOT_FOUND = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PLAN,
        S_MOVE,
        S_PLACE
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic plan;
        logic move;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic plan_move;
        logic move_done;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

[hw/rtl/dott_if.sv]
// request and result channel interfaces
`default_nettype none

interface dott_req_if;
    import dott_pkg::*;

    logic               valid;
    logic               ready;
    logic               mode;
    logic [KIND_W-1:0]  task_kind;
    logic [NUM_W-1:0]   task_number;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;

    modport source (
        output valid, mode, task_kind, task_number, month, day,
        input  ready
    );
    modport sink (
        input  valid, mode, task_kind, task_number, month, day,
        output ready
    );
endinterface

interface dott_rsp_if;
    import dott_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [OCC_W-1:0]    occupancy;

    modport source (
        output valid, status, position, occupancy,
        input  ready
    );
    modport sink (
        input  valid, status, position, occupancy,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/dott_dpath.sv]
// datapath: entry memory, scan, shift and result registers
`default_nettype none

module dott_dpath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_wdata,
    input  wire logic                          req_mode,
    input  wire logic [dott_pkg::KIND_W-1:0]   req_kind,
    input  wire logic [dott_pkg::NUM_W-1:0]    req_number,
    input  wire logic [dott_pkg::MONTH_W-1:0]  req_month,
    input  wire logic [dott_pkg::DAY_W-1:0]    req_day,
    input  wire dott_pkg::ctrl_cmd_t           cmd,
    output dott_pkg::dp_stat_t                 stat,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [dott_pkg::STATUS_W-1:0]      out_status,
    output logic [dott_pkg::POS_W-1:0]         out_position,
    output logic [dott_pkg::OCC_W-1:0]         out_occupancy
);
    import dott_pkg::*;

    logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

    logic               ordered_reg;
    logic [CNT_W-1:0]   count_reg;

    logic               item_mode_reg;
    logic [KEY_W-1:0]   item_key_reg;
    logic [DATE_W-1:0]  item_date_reg;

    logic [ENTRY_W-1:0] rd_data_reg;
    logic               rd_vld_reg;
    logic [IDX_W-1:0]   rd_idx_reg;

    logic [CNT_W-1:0]   scan_cnt_reg;
    logic               match_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [DATE_W-1:0]  match_date_reg;
    logic               gt_found_reg;
    logic [IDX_W-1:0]   gt_reg;

    logic               mv_up_reg;
    logic [CNT_W-1:0]   mv_src_reg;
    logic [CNT_W-1:0]   mv_left_reg;

    status_t            res_status_reg;
    logic [CNT_W-1:0]   res_pos_reg;
    logic               place_reg;
    logic [CNT_W-1:0]   place_addr_reg;
    logic               inc_reg;
    logic               dec_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [POS_W-1:0]    out_position_reg;
    logic [OCC_W-1:0]    out_occupancy_reg;

    // read port and scan compare
    logic               scan_issue;
    logic               move_issue;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [KEY_W-1:0]   rd_key;
    logic [DATE_W-1:0]  rd_date;
    logic               eval;
    logic               hit;
    logic               later;

    // write port
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    // plan
    logic [CNT_W-1:0]   idx_w;
    logic [CNT_W-1:0]   gt_w;
    logic [CNT_W-1:0]   p_upd;
    logic [CNT_W-1:0]   p_add;
    logic               full;
    status_t            pl_status;
    logic [CNT_W-1:0]   pl_pos;
    logic               pl_move;
    logic               pl_up;
    logic [CNT_W-1:0]   pl_src;
    logic [CNT_W-1:0]   pl_left;
    logic               pl_place;
    logic [CNT_W-1:0]   pl_addr;
    logic               pl_inc;
    logic               pl_dec;
    logic [CNT_W-1:0]   count_after;

    assign scan_issue = cmd.scan && (scan_cnt_reg < count_reg);
    assign move_issue = cmd.move && (mv_left_reg != '0);
    assign rd_en      = scan_issue || move_issue;
    assign rd_addr    = scan_issue ? scan_cnt_reg[IDX_W-1:0] : mv_src_reg[IDX_W-1:0];

    assign rd_key  = rd_data_reg[ENTRY_W-1:DATE_W];
    assign rd_date = rd_data_reg[DATE_W-1:0];
    assign eval    = cmd.scan && rd_vld_reg;
    assign hit     = eval && (rd_key == item_key_reg) && !match_reg;
    assign later   = eval && (rd_key != item_key_reg) && (rd_date > item_date_reg)
                     && !gt_found_reg;

    assign full  = (count_reg == CNT_W'(TABLE_DEPTH));
    assign idx_w = CNT_W'(idx_reg);
    assign gt_w  = CNT_W'(gt_reg);

    // slot after removal of the matched entry
    always_comb
    begin
        if (!gt_found_reg)
        begin
            p_upd = count_reg - CNT_W'(1);
        end
        else if (gt_w > idx_w)
        begin
            p_upd = gt_w - CNT_W'(1);
        end
        else
        begin
            p_upd = gt_w;
        end
        p_add = gt_found_reg ? gt_w : count_reg;
    end

    always_comb
    begin
        pl_status = ST_NOT_FOUND;
        pl_pos    = '0;
        pl_move   = 1'b0;
        pl_up     = 1'b0;
        pl_src    = '0;
        pl_left   = '0;
        pl_place  = 1'b0;
        pl_addr   = '0;
        pl_inc    = 1'b0;
        pl_dec    = 1'b0;
        if (!item_mode_reg)
        begin
            if (match_reg)
            begin
                if (ordered_reg && (match_date_reg == item_date_reg))
                begin
                    pl_status = ST_UNCHANGED;
                    pl_pos    = idx_w;
                end
                else if (ordered_reg)
                begin
                    pl_status = ST_UPDATED;
                    pl_pos    = p_upd;
                    pl_place  = 1'b1;
                    pl_addr   = p_upd;
                    if (p_upd < idx_w)
                    begin
                        pl_move = 1'b1;
                        pl_up   = 1'b1;
                        pl_src  = idx_w - CNT_W'(1);
                        pl_left = idx_w - p_upd;
                    end
                    else if (p_upd > idx_w)
                    begin
                        pl_move = 1'b1;
                        pl_src  = idx_w + CNT_W'(1);
                        pl_left = p_upd - idx_w;
                    end
                end
                else
                begin
                    pl_status = ST_UPDATED;
                    pl_pos    = idx_w;
                    pl_place  = 1'b1;
                    pl_addr   = idx_w;
                end
            end
            else if (full)
            begin
                pl_status = ST_FULL;
            end
            else if (ordered_reg)
            begin
                pl_status = ST_ADDED;
                pl_pos    = p_add;
                pl_place  = 1'b1;
                pl_addr   = p_add;
                pl_inc    = 1'b1;
                if (p_add < count_reg)
                begin
                    pl_move = 1'b1;
                    pl_up   = 1'b1;
                    pl_src  = count_reg - CNT_W'(1);
                    pl_left = count_reg - p_add;
                end
            end
            else
            begin
                pl_status = ST_ADDED;
                pl_pos    = count_reg;
                pl_place  = 1'b1;
                pl_addr   = count_reg;
                pl_inc    = 1'b1;
            end
        end
        else if (match_reg)
        begin
            pl_status = (match_date_reg >= item_date_reg) ? ST_ON_TIME : ST_OVERDUE;
            pl_pos    = idx_w;
            pl_dec    = 1'b1;
            if ((idx_w + CNT_W'(1)) < count_reg)
            begin
                pl_move = 1'b1;
                pl_src  = idx_w + CNT_W'(1);
                pl_left = count_reg - idx_w - CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        count_after = count_reg;
        if (inc_reg)
        begin
            count_after = count_reg + CNT_W'(1);
        end
        else if (dec_reg)
        begin
            count_after = count_reg - CNT_W'(1);
        end
    end

    // shift writes land one slot up or down from where they were read
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = rd_data_reg;
        if (cmd.move && rd_vld_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = mv_up_reg ? (rd_idx_reg + IDX_W'(1)) : (rd_idx_reg - IDX_W'(1));
        end
        else if (cmd.commit && place_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = place_addr_reg[IDX_W-1:0];
            wr_data = {item_key_reg, item_date_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        rd_idx_reg <= rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ordered_reg   <= 1'b0;
            count_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ordered_reg <= cfg_wdata;
            end
            rd_vld_reg <= rd_en;
            if (cmd.commit)
            begin
                count_reg     <= count_after;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_mode_reg <= req_mode;
            item_key_reg  <= {req_kind, req_number};
            item_date_reg <= {req_month, req_day};
            scan_cnt_reg  <= '0;
            match_reg     <= 1'b0;
            gt_found_reg  <= 1'b0;
        end
        else
        begin
            if (scan_issue)
            begin
                scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
            end
            if (hit)
            begin
                match_reg      <= 1'b1;
                idx_reg        <= rd_idx_reg;
                match_date_reg <= rd_date;
            end
            if (later)
            begin
                gt_found_reg <= 1'b1;
                gt_reg       <= rd_idx_reg;
            end
        end

        if (cmd.plan)
        begin
            res_status_reg <= pl_status;
            res_pos_reg    <= pl_pos;
            place_reg      <= pl_place;
            place_addr_reg <= pl_addr;
            inc_reg        <= pl_inc;
            dec_reg        <= pl_dec;
            mv_up_reg      <= pl_up;
            mv_src_reg     <= pl_src;
            mv_left_reg    <= pl_left;
        end
        else if (move_issue)
        begin
            mv_src_reg  <= mv_up_reg ? (mv_src_reg - CNT_W'(1)) : (mv_src_reg + CNT_W'(1));
            mv_left_reg <= mv_left_reg - CNT_W'(1);
        end

        if (cmd.commit)
        begin
            out_status_reg    <= res_status_reg;
            out_position_reg  <= POS_W'(res_pos_reg);
            out_occupancy_reg <= OCC_W'(count_after);
        end
    end

    assign stat.scan_done = (scan_cnt_reg >= count_reg) && !rd_vld_reg;
    assign stat.plan_move = pl_move;
    assign stat.move_done = (mv_left_reg == '0) && !rd_vld_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign out_status    = out_status_reg;
    assign out_position  = out_position_reg;
    assign out_occupancy = out_occupancy_reg;

endmodule

`default_nettype wire

[hw/rtl/dott_ctrl.sv]
// controller state machine: sequences scan, plan, shift and commit
`default_nettype none

module dott_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire dott_pkg::dp_stat_t stat,
    output dott_pkg::ctrl_cmd_t     cmd
);
    import dott_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_PLAN;
                end
            end
            S_PLAN:
            begin
                state_next = stat.plan_move ? S_MOVE : S_PLACE;
            end
            S_MOVE:
            begin
                if (stat.move_done)
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            S_PLAN:
            begin
                cmd.plan = 1'b1;
            end
            S_MOVE:
            begin
                cmd.move = 1'b1;
            end
            S_PLACE:
            begin
                cmd.commit = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/deadline_ordered_task_table_unit.sv]
// top level: deadline ordered task table, controller plus datapath
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+-------------------------------------------
//  req      | in  | valid / ready    | mode, task_kind, task_number, month, day
//  rsp      | out | valid / ready    | status, position, occupancy
//  cfg      | in  | cfg_we           | cfg_wdata (ordered mode bit)
//
//  an item is scanned over its n held entries (one scan read per cycle), then planned;
//  then m entries are shifted if needed (one per cycle, m at most n), then it is committed;
//  scan and shift each end with a drain of the read register and a done check
//  one item at a time; the next item is taken once the result sits in the output register
//  a result waiting on rsp holds the following item in its commit step
//  reset clears the entry count, ordered mode and both valid flags; memory needs no clear
`default_nettype none

module deadline_ordered_task_table_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   cfg_we,
    input  wire logic   cfg_wdata,
    dott_req_if.sink    req,
    dott_rsp_if.source  rsp
);
    import dott_pkg::*;

    // command and status between the controller and the datapath
    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // sequencer: idle, key scan, plan, shift, commit
    dott_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // entry memory, scan compare, shift pipeline and result register
    dott_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .req_mode      (req.mode),
        .req_kind      (req.task_kind),
        .req_number    (req.task_number),
        .req_month     (req.month),
        .req_day       (req.day),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (rsp.valid),
        .out_ready     (rsp.ready),
        .out_status    (rsp.status),
        .out_position  (rsp.position),
        .out_occupancy (rsp.occupancy)
    );

endmodule

`default_nettype wire

[hw/rtl/dott_checker.sv]
// port-level assertions for the task table, bound to the top level
`default_nettype none

`include "deadline_ordered_task_table_unit_assert.svh"

module dott_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    input  wire logic                          req_ready,
    input  wire logic                          rsp_valid,
    input  wire logic                          rsp_ready,
    input  wire logic [dott_pkg::STATUS_W-1:0] rsp_status,
    input  wire logic [dott_pkg::POS_W-1:0]    rsp_position,
    input  wire logic [dott_pkg::OCC_W-1:0]    rsp_occupancy
);
    import dott_pkg::*;

    // stalled result holds
    `DOTT_ASSERT_IMPL(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_position) && $stable(rsp_occupancy))

    // one item at a time: ready drops right after an accept
    `DOTT_ASSERT_IMPL(a_one_at_a_time, clk, rst_n, req_valid && req_ready |=> !req_ready)

    // full report only with a full table
    `DOTT_ASSERT_IMPL(a_full_occ, clk, rst_n, rsp_valid && (rsp_status == ST_FULL) |-> rsp_occupancy == OCC_W'(TABLE_DEPTH))

    // a miss reports slot zero
    `DOTT_ASSERT_IMPL(a_miss_pos, clk, rst_n, rsp_valid && (rsp_status == ST_NOT_FOUND) |-> rsp_position == '0)

    // unchanged needs an entry that is still held
    `DOTT_ASSERT_NEVER(a_unchanged_empty, clk, rst_n, rsp_valid && (rsp_status == ST_UNCHANGED) && (rsp_occupancy == '0))

endmodule

bind deadline_ordered_task_table_unit dott_checker u_dott_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_status    (rsp.status),
    .rsp_position  (rsp.position),
    .rsp_occupancy (rsp.occupancy)
);

`default_nettype wire
